// ===== hdl/tnae_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package tnae_pkg;

    localparam int VertexDepthDefault = 4096;
    localparam int CoordFracDefault   = 16;

    localparam int CoordW   = 32;
    localparam int SlotW    = 12;
    localparam int CornerW  = 16;
    localparam int CountW   = 13;
    localparam int MinLenW  = 16;
    localparam int NormW    = 16;
    localparam int AreaW    = 48;
    localparam int CrossW   = 64;
    localparam int SqW      = 128;
    localparam int RootW    = 64;
    localparam int MulW     = 33;
    localparam int NormFrac = 15;
    localparam int QuotW    = NormFrac + 2;
    localparam int StepW    = 7;

    localparam int MulLast  = 6;
    localparam int SqLast   = 12;
    localparam int SqrtLast = RootW - 1;
    localparam int DivLast  = QuotW - 1;

    localparam logic [NormW-1:0] NormOne = 16'h7FFF;

    // register indexes on the configuration port
    localparam logic RegVertexCount = 1'b0;
    localparam logic RegMinLength   = 1'b1;

    typedef enum logic [1:0] {
        SEL_A = 2'd0,
        SEL_B = 2'd1,
        SEL_C = 2'd2
    } rd_sel_t;

    typedef struct packed {
        logic              capture;
        logic              wr_vtx;
        logic              rd_en;
        rd_sel_t           rd_sel;
        logic              cap_a;
        logic              cap_b;
        logic              mk_edge;
        logic              mul;
        logic              mag;
        logic              sq;
        logic              sqrt;
        logic              div_init;
        logic              div;
        logic              finish;
        logic [StepW-1:0]  step;
    } cmd_t;

    typedef struct packed {
        logic idx_ok;
        logic dflt;
    } sts_t;

endpackage

`default_nettype wire

// ===== hdl/tnae_dp.sv =====
`timescale 1ns / 1ps
`default_nettype none

module tnae_dp #(
    parameter int VERTEX_DEPTH    = tnae_pkg::VertexDepthDefault,
    parameter int COORD_FRAC_BITS = tnae_pkg::CoordFracDefault
) (
    input  wire logic                                  aclk,
    input  wire logic                                  aresetn,
    input  wire tnae_pkg::cmd_t                        cmd,
    output      tnae_pkg::sts_t                        sts,
    input  wire logic [tnae_pkg::CountW-1:0]           vertex_count,
    input  wire logic [tnae_pkg::MinLenW-1:0]          min_normal_length,
    input  wire logic [tnae_pkg::SlotW-1:0]            s_vertex_slot,
    input  wire logic signed [tnae_pkg::CoordW-1:0]    s_coord_x,
    input  wire logic signed [tnae_pkg::CoordW-1:0]    s_coord_y,
    input  wire logic signed [tnae_pkg::CoordW-1:0]    s_coord_z,
    input  wire logic [tnae_pkg::CornerW-1:0]          s_corner_a,
    input  wire logic [tnae_pkg::CornerW-1:0]          s_corner_b,
    input  wire logic [tnae_pkg::CornerW-1:0]          s_corner_c,
    input  wire logic                                  s_group_end,
    output      logic signed [tnae_pkg::NormW-1:0]     m_normal_x,
    output      logic signed [tnae_pkg::NormW-1:0]     m_normal_y,
    output      logic signed [tnae_pkg::NormW-1:0]     m_normal_z,
    output      logic                                  m_index_ok,
    output      logic                                  m_used_default,
    output      logic [tnae_pkg::AreaW-1:0]            m_face_area,
    output      logic [tnae_pkg::AreaW-1:0]            m_group_area,
    output      logic                                  m_group_done
);

    localparam int AddrW = $clog2(VERTEX_DEPTH);
    localparam int CW    = tnae_pkg::CoordW;
    localparam int XW    = tnae_pkg::CrossW;
    localparam int RW    = tnae_pkg::RootW;
    localparam int QW    = tnae_pkg::QuotW;
    localparam int NW    = tnae_pkg::NormW;
    localparam int AW    = tnae_pkg::AreaW;
    localparam int NumW  = RW + tnae_pkg::NormFrac + 1;

    function automatic logic signed [CW-1:0] sat_sub(input logic signed [CW-1:0] p,
                                                      input logic signed [CW-1:0] q);
        logic signed [CW:0] d;
        d = {p[CW-1], p} - {q[CW-1], q};
        if (d[CW] != d[CW-1]) begin
            sat_sub = d[CW] ? {1'b1, {(CW-1){1'b0}}} : {1'b0, {(CW-1){1'b1}}};
        end else begin
            sat_sub = d[CW-1:0];
        end
    endfunction

    function automatic logic [NW-1:0] to_norm(input logic neg, input logic [QW-1:0] q);
        logic [QW-1:0] nq;
        nq = {QW{1'b0}} - q;
        if (neg) begin
            to_norm = nq[NW-1:0];
        end else if (q > QW'(tnae_pkg::NormOne)) begin
            to_norm = tnae_pkg::NormOne;
        end else begin
            to_norm = q[NW-1:0];
        end
    endfunction

    // vertex store
    logic signed [CW-1:0] mem_x [VERTEX_DEPTH];
    logic signed [CW-1:0] mem_y [VERTEX_DEPTH];
    logic signed [CW-1:0] mem_z [VERTEX_DEPTH];
    logic signed [CW-1:0] rdx_reg, rdy_reg, rdz_reg;

    logic [AddrW-1:0] wr_addr, rd_addr;
    logic             slot_in;
    logic [AddrW-1:0] ca_reg, cb_reg, cc_reg;
    logic             ok_reg, gend_reg;

    logic signed [CW-1:0] ax_reg, ay_reg, az_reg, bx_reg, by_reg, bz_reg;
    logic signed [CW-1:0] ux_reg, uy_reg, uz_reg, vx_reg, vy_reg, vz_reg;

    logic signed [tnae_pkg::MulW-1:0] op_a, op_b;
    logic signed [2*tnae_pkg::MulW-1:0] prod_full;
    logic [XW-1:0] prod_reg;

    logic [XW-1:0] cross_reg [3];
    logic [XW-1:0] mag_reg [3];
    logic [XW-1:0] msel;
    logic [tnae_pkg::SqW-1:0] acc_reg;

    logic [RW+1:0] rem_reg;
    logic [RW+3:0] rem2, trial;
    logic [RW-1:0] root_reg;

    logic [RW-1:0] drem_reg [3];
    logic [QW-1:0] dlow_reg [3];
    logic [QW-1:0] q_reg [3];

    logic [tnae_pkg::StepW-1:0] pk;
    logic [RW-1:0]  area_full;
    logic [AW-1:0]  area;
    logic [AW:0]    sum_wide;
    logic [AW-1:0]  new_sum;
    logic [AW-1:0]  area_sum_reg;
    logic           dflt;

    assign wr_addr = AddrW'(s_vertex_slot);
    assign slot_in = 32'(s_vertex_slot) < VERTEX_DEPTH;

    always_comb begin
        case (cmd.rd_sel)
            tnae_pkg::SEL_A: rd_addr = ca_reg;
            tnae_pkg::SEL_B: rd_addr = cb_reg;
            tnae_pkg::SEL_C: rd_addr = cc_reg;
            default:         rd_addr = ca_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (cmd.wr_vtx && slot_in) begin
            mem_x[wr_addr] <= s_coord_x;
        end
        if (cmd.rd_en) begin
            rdx_reg <= mem_x[rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.wr_vtx && slot_in) begin
            mem_y[wr_addr] <= s_coord_y;
        end
        if (cmd.rd_en) begin
            rdy_reg <= mem_y[rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.wr_vtx && slot_in) begin
            mem_z[wr_addr] <= s_coord_z;
        end
        if (cmd.rd_en) begin
            rdz_reg <= mem_z[rd_addr];
        end
    end

    assign sts.idx_ok = (32'(s_corner_a) < 32'(vertex_count)) && (32'(s_corner_a) < VERTEX_DEPTH)
                     && (32'(s_corner_b) < 32'(vertex_count)) && (32'(s_corner_b) < VERTEX_DEPTH)
                     && (32'(s_corner_c) < 32'(vertex_count)) && (32'(s_corner_c) < VERTEX_DEPTH);
    assign dflt = (root_reg == '0) || (root_reg < RW'(min_normal_length));
    assign sts.dflt = dflt;

    // shared multiplier operand select
    always_comb begin
        case (cmd.step[3:2])
            2'd0:    msel = mag_reg[0];
            2'd1:    msel = mag_reg[1];
            default: msel = mag_reg[2];
        endcase
        if (cmd.sq) begin
            op_a = {1'b0, (cmd.step[1] ? msel[XW-1:32] : msel[31:0])};
            op_b = {1'b0, (cmd.step[0] ? msel[XW-1:32] : msel[31:0])};
        end else begin
            case (cmd.step)
                7'd0:    begin op_a = {uy_reg[CW-1], uy_reg}; op_b = {vz_reg[CW-1], vz_reg}; end
                7'd1:    begin op_a = {uz_reg[CW-1], uz_reg}; op_b = {vy_reg[CW-1], vy_reg}; end
                7'd2:    begin op_a = {uz_reg[CW-1], uz_reg}; op_b = {vx_reg[CW-1], vx_reg}; end
                7'd3:    begin op_a = {ux_reg[CW-1], ux_reg}; op_b = {vz_reg[CW-1], vz_reg}; end
                7'd4:    begin op_a = {ux_reg[CW-1], ux_reg}; op_b = {vy_reg[CW-1], vy_reg}; end
                7'd5:    begin op_a = {uy_reg[CW-1], uy_reg}; op_b = {vx_reg[CW-1], vx_reg}; end
                default: begin op_a = {uy_reg[CW-1], uy_reg}; op_b = {vz_reg[CW-1], vz_reg}; end
            endcase
        end
    end

    assign prod_full = op_a * op_b;
    assign pk        = cmd.step - 7'd1;

    assign rem2  = {rem_reg, acc_reg[tnae_pkg::SqW-1 -: 2]};
    assign trial = {2'b00, root_reg, 2'b01};

    always_ff @(posedge aclk) begin
        prod_reg <= prod_full[XW-1:0];

        if (cmd.capture) begin
            ca_reg   <= AddrW'(s_corner_a);
            cb_reg   <= AddrW'(s_corner_b);
            cc_reg   <= AddrW'(s_corner_c);
            ok_reg   <= sts.idx_ok;
            gend_reg <= s_group_end;
        end
        if (cmd.cap_a) begin
            ax_reg <= rdx_reg; ay_reg <= rdy_reg; az_reg <= rdz_reg;
        end
        if (cmd.cap_b) begin
            bx_reg <= rdx_reg; by_reg <= rdy_reg; bz_reg <= rdz_reg;
        end
        if (cmd.mk_edge) begin
            ux_reg <= sat_sub(bx_reg, ax_reg);
            uy_reg <= sat_sub(by_reg, ay_reg);
            uz_reg <= sat_sub(bz_reg, az_reg);
            vx_reg <= sat_sub(rdx_reg, ax_reg);
            vy_reg <= sat_sub(rdy_reg, ay_reg);
            vz_reg <= sat_sub(rdz_reg, az_reg);
        end

        // cross: each component is a product minus the next, wrapped to 64 bits
        if (cmd.mul && cmd.step != '0) begin
            case (pk)
                7'd0:    cross_reg[0] <= prod_reg;
                7'd1:    cross_reg[0] <= cross_reg[0] - prod_reg;
                7'd2:    cross_reg[1] <= prod_reg;
                7'd3:    cross_reg[1] <= cross_reg[1] - prod_reg;
                7'd4:    cross_reg[2] <= prod_reg;
                7'd5:    cross_reg[2] <= cross_reg[2] - prod_reg;
                default: ;
            endcase
        end

        if (cmd.mag) begin
            for (int i = 0; i < 3; i++) begin
                mag_reg[i] <= cross_reg[i][XW-1] ? ({XW{1'b0}} - cross_reg[i]) : cross_reg[i];
            end
            acc_reg  <= '0;
            rem_reg  <= '0;
            root_reg <= '0;
        end

        // sum of squares from 32x32 partial products
        if (cmd.sq && cmd.step != '0) begin
            case (pk[1:0])
                2'd0:    acc_reg <= acc_reg + {64'b0, prod_reg};
                2'd3:    acc_reg <= acc_reg + {prod_reg, 64'b0};
                default: acc_reg <= acc_reg + {32'b0, prod_reg, 32'b0};
            endcase
        end

        // one root bit per step, radicand shifts out of the accumulator
        if (cmd.sqrt) begin
            acc_reg <= acc_reg << 2;
            if (rem2 >= trial) begin
                rem_reg  <= (RW+2)'(rem2 - trial);
                root_reg <= {root_reg[RW-2:0], 1'b1};
            end else begin
                rem_reg  <= rem2[RW+1:0];
                root_reg <= {root_reg[RW-2:0], 1'b0};
            end
        end

        for (int i = 0; i < 3; i++) begin
            logic [NumW-1:0] num;
            logic [RW:0]     r2;
            num = {1'b0, mag_reg[i], {tnae_pkg::NormFrac{1'b0}}}
                + {{(NumW-RW){1'b0}}, (root_reg >> 1)};
            r2  = {drem_reg[i], dlow_reg[i][QW-1]};
            if (cmd.div_init) begin
                drem_reg[i] <= RW'(num[NumW-1:QW]);
                dlow_reg[i] <= num[QW-1:0];
                q_reg[i]    <= '0;
            end else if (cmd.div) begin
                dlow_reg[i] <= dlow_reg[i] << 1;
                if (r2 >= {1'b0, root_reg}) begin
                    drem_reg[i] <= RW'(r2 - {1'b0, root_reg});
                    q_reg[i]    <= {q_reg[i][QW-2:0], 1'b1};
                end else begin
                    drem_reg[i] <= r2[RW-1:0];
                    q_reg[i]    <= {q_reg[i][QW-2:0], 1'b0};
                end
            end
        end
    end

    // area: half the length, rounded half up, back to COORD_FRAC_BITS fraction bits
    assign area_full = (root_reg >> (COORD_FRAC_BITS + 1)) + RW'(root_reg[COORD_FRAC_BITS]);
    assign area      = (|area_full[RW-1:AW]) ? {AW{1'b1}} : area_full[AW-1:0];
    assign sum_wide  = {1'b0, area_sum_reg} + {1'b0, area};
    assign new_sum   = !ok_reg ? area_sum_reg
                     : (sum_wide[AW] ? {AW{1'b1}} : sum_wide[AW-1:0]);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            area_sum_reg <= '0;
        end else if (cmd.finish) begin
            area_sum_reg <= gend_reg ? '0 : new_sum;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.finish) begin
            m_index_ok   <= ok_reg;
            m_group_done <= gend_reg;
            m_group_area <= new_sum;
            if (!ok_reg) begin
                m_normal_x     <= '0;
                m_normal_y     <= '0;
                m_normal_z     <= '0;
                m_used_default <= 1'b0;
                m_face_area    <= '0;
            end else begin
                m_face_area    <= area;
                m_used_default <= dflt;
                if (dflt) begin
                    m_normal_x <= '0;
                    m_normal_y <= tnae_pkg::NormOne;
                    m_normal_z <= '0;
                end else begin
                    m_normal_x <= to_norm(cross_reg[0][XW-1], q_reg[0]);
                    m_normal_y <= to_norm(cross_reg[1][XW-1], q_reg[1]);
                    m_normal_z <= to_norm(cross_reg[2][XW-1], q_reg[2]);
                end
            end
        end
    end

endmodule

`default_nettype wire

// ===== hdl/tnae_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none

module tnae_ctrl (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            s_valid,
    output      logic            s_ready,
    input  wire logic            s_req_type,
    output      logic            m_valid,
    input  wire logic            m_ready,
    input  wire tnae_pkg::sts_t  sts,
    output      tnae_pkg::cmd_t  cmd
);

    typedef enum logic [10:0] {
        ST_IDLE  = 11'b00000000001,
        ST_RDA   = 11'b00000000010,
        ST_RDB   = 11'b00000000100,
        ST_RDC   = 11'b00000001000,
        ST_EDGE  = 11'b00000010000,
        ST_MUL   = 11'b00000100000,
        ST_MAG   = 11'b00001000000,
        ST_SQ    = 11'b00010000000,
        ST_SQRT  = 11'b00100000000,
        ST_DINIT = 11'b01000000000,
        ST_FIN   = 11'b10000000000
    } state_t;

    state_t state_reg, state_next;
    logic [tnae_pkg::StepW-1:0] cnt_reg, cnt_next;
    logic out_valid_reg, out_valid_next;
    logic div_phase_reg, div_phase_next;

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = out_valid_reg;

    always_comb begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        div_phase_next = div_phase_reg;
        cmd            = '0;
        cmd.step       = cnt_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    if (!s_req_type) begin
                        cmd.wr_vtx = 1'b1;
                    end else begin
                        cmd.capture = 1'b1;
                        state_next  = sts.idx_ok ? ST_RDA : ST_FIN;
                    end
                end
            end
            ST_RDA: begin
                cmd.rd_en  = 1'b1;
                cmd.rd_sel = tnae_pkg::SEL_A;
                state_next = ST_RDB;
            end
            ST_RDB: begin
                cmd.rd_en  = 1'b1;
                cmd.rd_sel = tnae_pkg::SEL_B;
                cmd.cap_a  = 1'b1;
                state_next = ST_RDC;
            end
            ST_RDC: begin
                cmd.rd_en  = 1'b1;
                cmd.rd_sel = tnae_pkg::SEL_C;
                cmd.cap_b  = 1'b1;
                state_next = ST_EDGE;
            end
            ST_EDGE: begin
                cmd.mk_edge = 1'b1;
                cnt_next    = '0;
                state_next  = ST_MUL;
            end
            ST_MUL: begin
                cmd.mul = 1'b1;
                if (cnt_reg == tnae_pkg::StepW'(tnae_pkg::MulLast)) begin
                    cnt_next   = '0;
                    state_next = ST_MAG;
                end else begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            ST_MAG: begin
                cmd.mag    = 1'b1;
                state_next = ST_SQ;
            end
            ST_SQ: begin
                cmd.sq = 1'b1;
                if (cnt_reg == tnae_pkg::StepW'(tnae_pkg::SqLast)) begin
                    cnt_next   = '0;
                    state_next = ST_SQRT;
                end else begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            ST_SQRT: begin
                cmd.sqrt = 1'b1;
                if (cnt_reg == tnae_pkg::StepW'(tnae_pkg::SqrtLast)) begin
                    cnt_next       = '0;
                    div_phase_next = 1'b0;
                    state_next     = ST_DINIT;
                end else begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            ST_DINIT: begin
                // first cycle loads the dividers, then one quotient bit per cycle
                if (!div_phase_reg) begin
                    cmd.div_init = 1'b1;
                    if (sts.dflt) begin
                        state_next = ST_FIN;
                    end else begin
                        div_phase_next = 1'b1;
                        cnt_next       = '0;
                    end
                end else begin
                    cmd.div = 1'b1;
                    if (cnt_reg == tnae_pkg::StepW'(tnae_pkg::DivLast)) begin
                        div_phase_next = 1'b0;
                        state_next     = ST_FIN;
                    end else begin
                        cnt_next = cnt_reg + 1'b1;
                    end
                end
            end
            ST_FIN: begin
                if (!out_valid_reg || m_ready) begin
                    cmd.finish = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        if (cmd.finish) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end else begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
            div_phase_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
            div_phase_reg <= div_phase_next;
        end
    end

    a_finish_shows: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.finish |=> m_valid)
        else $error("result register not marked full after finish");

    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.finish |-> (!out_valid_reg || m_ready))
        else $error("pending result overwritten");

    a_vertex_no_work: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && !s_req_type) |=> (state_reg == ST_IDLE))
        else $error("vertex write started face work");

    a_div_skip: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.div) |-> !sts.dflt)
        else $error("division running on a degenerate face");

endmodule

`default_nettype wire

// ===== hdl/triangle_normal_area_engine.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Triangle normal and area engine. Vertex transfers (req_type 0) write a Q16.16
// coordinate triple into the on-chip vertex store and produce no result. Face
// transfers (req_type 1) name three corners; each face yields one result
// transfer with the Q1.15 unit normal, the Q32.16 area and the running,
// saturating group area, which clears after a face marked group_end. A face with a
// corner at or above vertex_count or VERTEX_DEPTH is flagged with index_ok low
// and adds nothing. A valid face runs through 3 store reads, the cross product on
// the shared 33x33 multiplier, the squared length on that multiplier too, the
// bit-serial square root and the three parallel bit-serial dividers (skipped,
// with normal 0,1,0, when the length is zero or below min_normal_length). The
// input side takes one item at a time, while a finished result waits in its own
// output register. Registers: 0x0 vertex_count, 0x4 min_normal_length; write
// them only while the engine is idle.
module triangle_normal_area_engine #(
    parameter int VERTEX_DEPTH    = tnae_pkg::VertexDepthDefault,
    parameter int COORD_FRAC_BITS = tnae_pkg::CoordFracDefault
) (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    // configuration port
    input  wire logic                                psel,
    input  wire logic                                penable,
    input  wire logic                                pwrite,
    input  wire logic [2:0]                          paddr,
    input  wire logic [31:0]                         pwdata,
    output      logic [31:0]                         prdata,
    output      logic                                pready,
    // input items
    input  wire logic                                s_valid,
    output      logic                                s_ready,
    input  wire logic                                s_req_type,
    input  wire logic [tnae_pkg::SlotW-1:0]          s_vertex_slot,
    input  wire logic signed [tnae_pkg::CoordW-1:0]  s_coord_x,
    input  wire logic signed [tnae_pkg::CoordW-1:0]  s_coord_y,
    input  wire logic signed [tnae_pkg::CoordW-1:0]  s_coord_z,
    input  wire logic [tnae_pkg::CornerW-1:0]        s_corner_a,
    input  wire logic [tnae_pkg::CornerW-1:0]        s_corner_b,
    input  wire logic [tnae_pkg::CornerW-1:0]        s_corner_c,
    input  wire logic                                s_group_end,
    // result items
    output      logic                                m_valid,
    input  wire logic                                m_ready,
    output      logic signed [tnae_pkg::NormW-1:0]   m_normal_x,
    output      logic signed [tnae_pkg::NormW-1:0]   m_normal_y,
    output      logic signed [tnae_pkg::NormW-1:0]   m_normal_z,
    output      logic                                m_index_ok,
    output      logic                                m_used_default,
    output      logic [tnae_pkg::AreaW-1:0]          m_face_area,
    output      logic [tnae_pkg::AreaW-1:0]          m_group_area,
    output      logic                                m_group_done
);

    logic [tnae_pkg::CountW-1:0]  vertex_count_reg;
    logic [tnae_pkg::MinLenW-1:0] min_len_reg;
    logic                         reg_wr;
    logic                         reg_idx;

    tnae_pkg::cmd_t cmd;
    tnae_pkg::sts_t sts;

    assign pready  = 1'b1;
    assign reg_idx = paddr[2];
    assign reg_wr  = psel && penable && pwrite;

    // register writes land in the access cycle
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vertex_count_reg <= '0;
            min_len_reg      <= 16'd43;
        end else if (reg_wr) begin
            case (reg_idx)
                tnae_pkg::RegVertexCount: vertex_count_reg <= pwdata[tnae_pkg::CountW-1:0];
                tnae_pkg::RegMinLength:   min_len_reg      <= pwdata[tnae_pkg::MinLenW-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            tnae_pkg::RegVertexCount: prdata = {19'b0, vertex_count_reg};
            tnae_pkg::RegMinLength:   prdata = {16'b0, min_len_reg};
            default:                  prdata = '0;
        endcase
    end

    // sequencer: walks a face through read, cross, length, root and divide steps
    tnae_ctrl u_ctrl (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_req_type (s_req_type),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .sts        (sts),
        .cmd        (cmd)
    );

    // vertex store, shared multiplier, root and dividers, result register
    tnae_dp #(
        .VERTEX_DEPTH    (VERTEX_DEPTH),
        .COORD_FRAC_BITS (COORD_FRAC_BITS)
    ) u_dp (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cmd               (cmd),
        .sts               (sts),
        .vertex_count      (vertex_count_reg),
        .min_normal_length (min_len_reg),
        .s_vertex_slot     (s_vertex_slot),
        .s_coord_x         (s_coord_x),
        .s_coord_y         (s_coord_y),
        .s_coord_z         (s_coord_z),
        .s_corner_a        (s_corner_a),
        .s_corner_b        (s_corner_b),
        .s_corner_c        (s_corner_c),
        .s_group_end       (s_group_end),
        .m_normal_x        (m_normal_x),
        .m_normal_y        (m_normal_y),
        .m_normal_z        (m_normal_z),
        .m_index_ok        (m_index_ok),
        .m_used_default    (m_used_default),
        .m_face_area       (m_face_area),
        .m_group_area      (m_group_area),
        .m_group_done      (m_group_done)
    );

endmodule

`default_nettype wire
